>>> rtl/msr_pkg.sv
// Shared types, constants and helper functions for the marker secret redactor.
`default_nettype none

package msr_pkg;

	// Longest marker the matcher compares.
	localparam int MARKER_BYTES = 24;
	localparam int MARKER_BITS  = MARKER_BYTES * 8;
	localparam int TERM_SET_BITS = 256;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_INDEX_BITS = 3;

	// Character codes that steer the scan.
	localparam logic [7:0] CHAR_NL = 8'd10;
	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] WS_MAX  = 8'd32;

	// Replacement text length and the index of its last character.
	localparam int REDACT_LEN = 10;
	localparam logic [3:0] REDACT_LAST = 4'(REDACT_LEN - 1);

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MARKER_0 = 3'd0,
		REG_MARKER_1 = 3'd1,
		REG_MARKER_2 = 3'd2,
		REG_RULE     = 3'd3,
		REG_SET_0    = 3'd4,
		REG_SET_1    = 3'd5,
		REG_SET_2    = 3'd6,
		REG_SET_3    = 3'd7
	} cfg_reg_t;

	// Stop test selection.
	typedef enum logic [1:0] {
		STOP_WS         = 2'd0,
		STOP_MATCH_BYTE = 2'd1,
		STOP_IN_SET     = 2'd2,
		STOP_WS_ALT     = 2'd3
	} stop_mode_t;

	// Decoded rule configuration.
	typedef struct packed {
		logic [MARKER_BITS-1:0]   marker;
		logic [TERM_SET_BITS-1:0] term_set;
		logic [15:0]              cap;
		logic [7:0]               stop_byte;
		logic [4:0]               marker_len;
		stop_mode_t               stop_mode;
	} cfg_t;

	// Input beat.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_beat_t;

	// Output beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_beat_t;

	// Work for the back end: optional replacement before the byte, the byte itself,
	// and optional replacement after it.
	typedef struct packed {
		logic       pre_redact;
		logic       has_byte;
		logic       post_redact;
		logic [7:0] data;
	} desc_t;

	// One character of the replacement text.
	function automatic logic [7:0] redact_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "[";
			4'd1: c = "R";
			4'd2: c = "E";
			4'd3: c = "D";
			4'd4: c = "A";
			4'd5: c = "C";
			4'd6: c = "T";
			4'd7: c = "E";
			4'd8: c = "D";
			4'd9: c = "]";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Byte k of the marker; bytes beyond the stored marker read as zero.
	function automatic logic [7:0] marker_byte(input logic [MARKER_BITS-1:0] m,
			input logic [4:0] k);
		logic [7:0] b;
		b = 8'h00;
		if (int'(k) < MARKER_BYTES) begin
			b = m[{k, 3'b000} +: 8];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/marker_secret_redactor.sv
// Top level of the marker secret redactor: configuration registers, front end, queue, back end.
//
// Text bytes enter on in_valid/in_stall/in_data, one beat per byte with an end-of-text flag.
// Redacted text leaves on out_valid/out_stall/out_data; run_last marks the final beat
// caused by one input byte. A byte that passes through is written into the queue and then
// loaded into the output register; a byte that closes a run adds the ten-byte [REDACTED]
// text before or after it. Throughput is one byte per cycle while no replacement is emitted
// and the receiver does not stall; an input byte yields 1, 10 or 11 output beats. Its work
// item stays queued until its last beat is loaded, so one more byte that yields beats fits.
// Carriage returns and swallowed bytes produce no beat of their own. When the receiver stalls,
// the output beat holds and the queue fills; in_stall rises once both queue entries are taken.
// Configuration is written through cfg_en/cfg_index/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Reset clears the
// configuration and all scan state; the block takes bytes on the first cycle after reset.
`default_nettype none

module marker_secret_redactor (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_en,
	input  wire logic [msr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [msr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire msr_pkg::in_beat_t                     in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output msr_pkg::out_beat_t                         out_data
);
	import msr_pkg::*;

	cfg_t  cfg_q;
	logic  q_full;
	logic  push;
	desc_t push_desc;
	logic  pop;
	logic  head_valid;
	desc_t head_desc;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MARKER_0: cfg_q.marker[63:0]    <= cfg_data;
				REG_MARKER_1: cfg_q.marker[127:64]  <= cfg_data;
				REG_MARKER_2: cfg_q.marker[191:128] <= cfg_data;
				REG_RULE: begin
					cfg_q.stop_mode  <= stop_mode_t'(cfg_data[1:0]);
					cfg_q.marker_len <= cfg_data[6:2];
					cfg_q.stop_byte  <= cfg_data[14:7];
					cfg_q.cap        <= cfg_data[30:15];
				end
				REG_SET_0: cfg_q.term_set[63:0]    <= cfg_data;
				REG_SET_1: cfg_q.term_set[127:64]  <= cfg_data;
				REG_SET_2: cfg_q.term_set[191:128] <= cfg_data;
				REG_SET_3: cfg_q.term_set[255:192] <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	msr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	msr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	msr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// A beat that is not the last of its byte is always followed by more beats.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.run_last) |=> out_valid)
		else $error("output went idle in the middle of a byte's beats");

	// The back end only retires work that is in the queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("work retired from an empty queue");

	// Queued work never asks for a replacement both before and after its byte.
	a_one_redact: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(push_desc.pre_redact && push_desc.post_redact))
		else $error("work item carries two replacements");

endmodule

`default_nettype wire

>>> rtl/msr_front.sv
// Front end: accepts text bytes, runs the marker scan and run tracking, and queues work.
`default_nettype none

module msr_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire msr_pkg::cfg_t    cfg,
	input  wire logic             in_valid,
	input  wire msr_pkg::in_beat_t in_data,
	output logic                  in_stall,
	input  wire logic             q_full,
	output logic                  push,
	output msr_pkg::desc_t        push_desc
);
	import msr_pkg::*;

	logic [7:0]  win_q [MARKER_BYTES];
	logic [7:0]  win_d [MARKER_BYTES];
	logic [4:0]  bsr_q, bsr_d;
	logic        sec_q, sec_d;
	logic [15:0] len_q, len_d;

	logic        accept;
	logic [7:0]  b;
	logic        is_stop;
	logic        rule_on;
	logic [4:0]  bsr_base;
	logic [4:0]  bsr_scan;
	logic        match;
	logic [15:0] len_inc;
	desc_t       desc;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign b        = in_data.data_byte;

	// Stop test on the incoming byte.
	always_comb begin
		case (cfg.stop_mode)
			STOP_MATCH_BYTE: is_stop = (b == cfg.stop_byte);
			STOP_IN_SET:     is_stop = cfg.term_set[b];
			default:         is_stop = (b <= WS_MAX);
		endcase
	end

	assign rule_on = (cfg.marker_len != 5'd0) && (int'(cfg.marker_len) <= MARKER_BYTES);

	// A scan inside a run only happens on its stop byte, which restarts the count.
	assign bsr_base = sec_q ? 5'd0 : bsr_q;
	assign bsr_scan = (int'(bsr_base) < MARKER_BYTES) ? bsr_base + 5'd1 : bsr_base;

	// Compare the newest bytes, with this byte included, against the marker tail.
	always_comb begin
		logic [4:0] idx;
		logic [7:0] tap;
		match = rule_on && (bsr_scan >= cfg.marker_len);
		for (int j = 0; j < MARKER_BYTES; j++) begin
			idx = cfg.marker_len - 5'd1 - 5'(j);
			tap = (j == 0) ? b : win_q[MARKER_BYTES - j];
			if (5'(j) < cfg.marker_len) begin
				if (tap != marker_byte(cfg.marker, idx)) begin
					match = 1'b0;
				end
			end
		end
	end

	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + 16'd1;

	// Classification of the byte and next scan state.
	always_comb begin
		logic do_scan;
		do_scan = 1'b0;
		win_d   = win_q;
		bsr_d   = bsr_q;
		sec_d   = sec_q;
		len_d   = len_q;
		desc    = '0;
		desc.data = b;
		if (b == CHAR_CR) begin
			desc.has_byte = 1'b0;
		end else if (b == CHAR_NL) begin
			desc.pre_redact = sec_q;
			desc.has_byte   = 1'b1;
			sec_d = 1'b0;
			len_d = '0;
			bsr_d = '0;
		end else if (sec_q) begin
			if (is_stop) begin
				desc.pre_redact = 1'b1;
				desc.has_byte   = 1'b1;
				sec_d   = 1'b0;
				len_d   = '0;
				do_scan = 1'b1;
			end else begin
				len_d = len_inc;
				if (cfg.cap != 16'd0 && len_inc >= cfg.cap) begin
					desc.pre_redact = 1'b1;
					sec_d = 1'b0;
					len_d = '0;
					bsr_d = '0;
				end
			end
		end else begin
			desc.has_byte = 1'b1;
			do_scan = 1'b1;
		end
		if (do_scan) begin
			for (int i = 0; i < MARKER_BYTES - 1; i++) begin
				win_d[i] = win_q[i + 1];
			end
			win_d[MARKER_BYTES - 1] = b;
			bsr_d = bsr_scan;
			if (match) begin
				sec_d = 1'b1;
				len_d = '0;
			end
		end
		// End of text closes a pending run and clears the scan state.
		if (in_data.end_of_text) begin
			if (sec_d && !desc.pre_redact) begin
				if (desc.has_byte) begin
					desc.post_redact = 1'b1;
				end else begin
					desc.pre_redact = 1'b1;
				end
			end
			sec_d = 1'b0;
			len_d = '0;
			bsr_d = '0;
		end
	end

	assign push      = accept && (desc.pre_redact || desc.has_byte);
	assign push_desc = desc;

	// Scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsr_q <= '0;
			sec_q <= 1'b0;
			len_q <= '0;
		end else if (accept) begin
			bsr_q <= bsr_d;
			sec_q <= sec_d;
			len_q <= len_d;
		end
	end

	// Recent byte window, payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/msr_queue.sv
// Two-entry work queue between the front end and the back end.
`default_nettype none

module msr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire msr_pkg::desc_t push_desc,
	input  wire logic           pop,
	output logic                full,
	output logic                head_valid,
	output msr_pkg::desc_t      head_desc
);
	import msr_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

>>> rtl/msr_back.sv
// Back end: expands queued work into output beats through an output register.
`default_nettype none

module msr_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire msr_pkg::desc_t head_desc,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output msr_pkg::out_beat_t  out_data
);
	import msr_pkg::*;

	logic [3:0] idx_q;
	logic       out_valid_q;
	out_beat_t  out_data_q;

	logic       load;
	logic       has_redact;
	logic [3:0] last_idx;
	logic [3:0] byte_pos;
	logic [3:0] red_off;
	logic       is_last;
	out_beat_t  beat;

	assign load = head_valid && (!out_valid_q || !out_stall);

	// Beat positions of the byte and the replacement text within this work item.
	assign has_redact = head_desc.pre_redact || head_desc.post_redact;
	assign byte_pos   = head_desc.pre_redact ? 4'(REDACT_LEN) : 4'd0;
	assign red_off    = head_desc.post_redact ? 4'd1 : 4'd0;
	assign last_idx   = head_desc.has_byte ? (has_redact ? 4'(REDACT_LEN) : 4'd0) : REDACT_LAST;
	assign is_last    = (idx_q == last_idx);

	always_comb begin
		if (head_desc.has_byte && idx_q == byte_pos) begin
			beat.out_byte = head_desc.data;
		end else begin
			beat.out_byte = redact_char(idx_q - red_off);
		end
		beat.run_last = is_last;
	end

	assign pop = load && is_last;

	// Beat counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? 4'd0 : idx_q + 4'd1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

>>> tb/marker_secret_redactor_tb.sv
// Self-checking testbench for the marker secret redactor: directed table, then random text.
`timescale 1ns / 1ps

module marker_secret_redactor_tb;
	import msr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_SHOWN = 10;
	localparam logic [79:0] REDACTED_TEXT = "[REDACTED]";

	// How a row of the directed table is checked, or that it writes a register.
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_PASS,
		ROW_DROP,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_reg_t    reg_index;
		logic [63:0] value;
		logic [7:0]  data_byte;
		logic        end_of_text;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;

	// Shadow copy of the rule registers and of the scan state.
	logic [MARKER_BITS-1:0] marker_bits = '0;
	logic [30:0] rule_bits = '0;
	logic [TERM_SET_BITS-1:0] term_set_bits = '0;
	logic [7:0] history [0:MARKER_BYTES-1];
	int scanned_count = 0;
	logic in_secret = 1'b0;
	logic [15:0] secret_count = '0;

	out_beat_t step_results[$];
	out_beat_t expected_text[$];
	stim_row_t directed_rows[$];
	int error_count = 0;
	int idle_pct = 19;
	int stall_pct = 19;
	logic [7:0] set_member = '0;

	marker_secret_redactor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_en(cfg_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	function automatic logic [30:0] rule_word(input logic [15:0] cap, input logic [7:0] stop,
			input logic [4:0] len, input stop_mode_t mode);
		return {cap, stop, len, mode};
	endfunction

	function automatic stim_row_t text_row(input row_kind_t kind, input logic [7:0] b,
			input logic last);
		stim_row_t row;
		row = '0;
		row.kind = kind;
		row.data_byte = b;
		row.end_of_text = last;
		return row;
	endfunction

	function automatic stim_row_t write_row(input cfg_reg_t idx, input logic [63:0] value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_index = idx;
		row.value = value;
		return row;
	endfunction

	// The block emits at most eleven beats per input byte.
	function automatic void add_text_byte(input logic [7:0] b);
		out_beat_t beat;
		beat.out_byte = b;
		beat.run_last = 1'b0;
		if (step_results.size() < 11) begin
			step_results.insert(step_results.size(), beat);
		end
	endfunction

	function automatic void add_redaction();
		int k;
		for (k = 0; k < REDACT_LEN; k++) begin
			add_text_byte(REDACTED_TEXT[79 - 8*k -: 8]);
		end
	endfunction

	function automatic void close_run();
		in_secret = 1'b0;
		secret_count = '0;
		scanned_count = 0;
	endfunction

	// Shift a byte into the history and arm a run when the marker ends here.
	function automatic void scan_for_marker(input logic [7:0] b);
		int len;
		int k;
		logic hit;
		len = int'(rule_bits[6:2]);
		for (k = 0; k < MARKER_BYTES - 1; k++) begin
			history[k] = history[k + 1];
		end
		history[MARKER_BYTES - 1] = b;
		if (scanned_count < MARKER_BYTES) begin
			scanned_count++;
		end
		if (len != 0 && len <= MARKER_BYTES && scanned_count >= len) begin
			hit = 1'b1;
			for (k = 0; k < len; k++) begin
				if (history[MARKER_BYTES - len + k] != marker_bits[8*k +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				in_secret = 1'b1;
				secret_count = '0;
			end
		end
	endfunction

	// Work out the beats that one input byte causes, into step_results.
	function automatic void predict_redaction(input in_beat_t beat);
		logic [7:0] b;
		logic [15:0] cap;
		logic stop;
		b = beat.data_byte;
		cap = rule_bits[30:15];
		step_results.delete();
		if (b == CHAR_NL) begin
			if (in_secret) begin
				add_redaction();
			end
			add_text_byte(b);
			close_run();
		end else if (b != CHAR_CR && in_secret) begin
			case (stop_mode_t'(rule_bits[1:0]))
				STOP_MATCH_BYTE: stop = (b == rule_bits[14:7]);
				STOP_IN_SET: stop = term_set_bits[b];
				default: stop = (b <= WS_MAX);
			endcase
			if (stop) begin
				add_redaction();
				add_text_byte(b);
				close_run();
				scan_for_marker(b);
			end else begin
				if (secret_count != LEN_MAX) begin
					secret_count++;
				end
				if (cap != 0 && secret_count >= cap) begin
					add_redaction();
					close_run();
				end
			end
		end else if (b != CHAR_CR) begin
			add_text_byte(b);
			scan_for_marker(b);
		end
		// A run still open at the end of the text is closed; its replacement is added unless this byte already emitted one.
		if (beat.end_of_text) begin
			if (in_secret && step_results.size() <= 1) begin
				add_redaction();
			end
			close_run();
		end
		if (step_results.size() != 0) begin
			step_results[step_results.size() - 1].run_last = 1'b1;
		end
	endfunction

	function automatic void report_mismatch(input string what, input out_beat_t want,
			input out_beat_t got);
		if (error_count < MAX_SHOWN) begin
			$display("%0t ns: %s: expected byte %02h last %0b, got byte %02h last %0b",
				$time, what, want.out_byte, want.run_last, got.out_byte, got.run_last);
		end
		error_count++;
	endfunction

	// Offer one text byte, wait for the beat to be taken, then record its results.
	task automatic send_text_byte(input logic [7:0] value, input logic last,
			input row_kind_t kind);
		in_beat_t beat;
		out_beat_t typed;
		beat.data_byte = value;
		beat.end_of_text = last;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_redaction(beat);
		case (kind)
			ROW_PASS: begin
				typed.out_byte = value;
				typed.run_last = 1'b1;
				expected_text.insert(expected_text.size(), typed);
			end
			ROW_DROP: ;
			default: begin
				foreach (step_results[i]) begin
					expected_text.insert(expected_text.size(), step_results[i]);
				end
			end
		endcase
	endtask

	// Hold the input off until every expected beat has arrived and the block has settled.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_text.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [63:0] value);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MARKER_0: marker_bits[63:0] = value;
			REG_MARKER_1: marker_bits[127:64] = value;
			REG_MARKER_2: marker_bits[191:128] = value;
			REG_RULE: rule_bits = value[30:0];
			REG_SET_0: term_set_bits[63:0] = value;
			REG_SET_1: term_set_bits[127:64] = value;
			REG_SET_2: term_set_bits[191:128] = value;
			default: term_set_bits[255:192] = value;
		endcase
	endtask

	// Pick a rule for one random phase and write all registers.
	task automatic program_phase(input int phase);
		logic [MARKER_BITS-1:0] marker;
		logic [TERM_SET_BITS-1:0] sets;
		logic [63:0] rule_value;
		stop_mode_t mode;
		logic [4:0] len;
		logic [15:0] cap;
		logic [7:0] stop;
		int k;
		for (k = 0; k < MARKER_BYTES; k++) begin
			marker[8*k +: 8] = 8'($urandom_range(33, 126));
		end
		for (k = 0; k < 8; k++) begin
			sets[32*k +: 32] = $urandom;
		end
		mode = stop_mode_t'($urandom_range(3));
		len = 5'($urandom_range(1, 4));
		stop = 8'($urandom);
		case ($urandom_range(3))
			0: cap = '0;
			1: cap = LEN_MAX;
			default: cap = 16'($urandom_range(1, 4));
		endcase
		rule_value = {$urandom, $urandom};
		if (phase == 1) begin
			mode = STOP_IN_SET;
			len = 5'(MARKER_BYTES);
			cap = '0;
		end else if (phase == 5) begin
			mode = STOP_MATCH_BYTE;
			len = 5'd1;
			cap = 16'd1;
			stop = marker[7:0];
		end
		rule_value[30:0] = rule_word(cap, stop, len, mode);
		// The first phase puts every register at its top value; the rule is then off.
		if (phase == 0) begin
			marker = '1;
			sets = '1;
			rule_value = '1;
		end
		set_member = 8'($urandom);
		sets[set_member] = 1'b1;
		write_register(REG_MARKER_0, marker[63:0]);
		write_register(REG_MARKER_1, marker[127:64]);
		write_register(REG_MARKER_2, marker[191:128]);
		write_register(REG_RULE, rule_value);
		write_register(REG_SET_0, sets[63:0]);
		write_register(REG_SET_1, sets[127:64]);
		write_register(REG_SET_2, sets[191:128]);
		write_register(REG_SET_3, sets[255:192]);
	endtask

	// Mostly marker, secret and terminator sequences, with noise bytes in between.
	task automatic send_random_text(input int budget);
		int sent;
		int mlen;
		int body;
		int k;
		logic [7:0] b;
		sent = 0;
		mlen = int'(rule_bits[6:2]);
		while (sent < budget) begin
			if ($urandom_range(99) < 65 && mlen >= 1 && mlen <= MARKER_BYTES) begin
				for (k = 0; k < mlen; k++) begin
					send_text_byte(marker_bits[8*k +: 8], 1'b0, ROW_PREDICT);
				end
				body = $urandom_range(4);
				for (k = 0; k < body; k++) begin
					b = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122));
					send_text_byte(b, 1'b0, ROW_PREDICT);
				end
				case ($urandom_range(4))
					0: begin
						case (stop_mode_t'(rule_bits[1:0]))
							STOP_MATCH_BYTE: b = rule_bits[14:7];
							STOP_IN_SET: b = set_member;
							default: b = 8'($urandom_range(0, 32));
						endcase
					end
					1: b = CHAR_NL;
					2: b = CHAR_CR;
					3: b = 8'($urandom);
					default: b = 8'($urandom_range(97, 122));
				endcase
				send_text_byte(b, ($urandom_range(15) == 0), ROW_PREDICT);
				sent += mlen + body + 1;
			end else begin
				case ($urandom_range(9))
					0: b = CHAR_NL;
					1: b = CHAR_CR;
					default: b = 8'($urandom);
				endcase
				send_text_byte(b, ($urandom_range(15) == 0), ROW_PREDICT);
				sent++;
			end
		end
		send_text_byte(8'($urandom), 1'b1, ROW_PREDICT);
	endtask

	// Receiver side: random stalls.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare every beat taken from the block with the oldest expected one.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				report_mismatch("beat with nothing expected", '0, out_data);
			end else begin
				want = expected_text.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					report_mismatch("out_byte differs", want, out_data);
				end else if (out_data.run_last !== want.run_last) begin
					report_mismatch("run_last differs", want, out_data);
				end
			end
		end
	end

	// Give up when nothing moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("marker_secret_redactor regression: fail");
		$finish;
	end

	initial begin
		int phase;
		int budget;
		// Rule off after reset and under an oversized marker length, then a two-byte marker
		// with a stop byte and then with a stop set, then a one-byte marker that is itself a stop byte.
		directed_rows = '{
			text_row(ROW_PASS, 8'h00, 1'b0),
			text_row(ROW_PASS, 8'hFF, 1'b0),
			text_row(ROW_DROP, CHAR_CR, 1'b0),
			text_row(ROW_PASS, CHAR_NL, 1'b1),
			write_row(REG_RULE, 64'(rule_word(16'd0, 8'h00, 5'd31, STOP_WS))),
			text_row(ROW_PASS, 8'h00, 1'b1),
			write_row(REG_MARKER_0, 64'h3D6B),
			write_row(REG_RULE, 64'(rule_word(16'd0, 8'h3B, 5'd2, STOP_MATCH_BYTE))),
			text_row(ROW_PREDICT, "k", 1'b0),
			text_row(ROW_PREDICT, "=", 1'b0),
			text_row(ROW_PREDICT, "x", 1'b0),
			text_row(ROW_PREDICT, " ", 1'b0),
			text_row(ROW_PREDICT, ";", 1'b0),
			text_row(ROW_PREDICT, "k", 1'b0),
			text_row(ROW_PREDICT, "=", 1'b0),
			text_row(ROW_PREDICT, CHAR_CR, 1'b1),
			write_row(REG_SET_0, 64'h0000_1000_0000_0000),
			write_row(REG_SET_3, 64'h8000_0000_0000_0000),
			write_row(REG_RULE, 64'(rule_word(16'd3, 8'h00, 5'd2, STOP_IN_SET))),
			text_row(ROW_PREDICT, "k", 1'b0),
			text_row(ROW_PREDICT, "=", 1'b0),
			text_row(ROW_PREDICT, "a", 1'b0),
			text_row(ROW_PREDICT, "b", 1'b0),
			text_row(ROW_PREDICT, "c", 1'b0),
			text_row(ROW_PREDICT, ",", 1'b0),
			write_row(REG_MARKER_0, 64'h20),
			write_row(REG_RULE, 64'(rule_word(16'd0, 8'h00, 5'd1, STOP_WS_ALT))),
			text_row(ROW_PREDICT, "a", 1'b0),
			text_row(ROW_PREDICT, " ", 1'b0),
			text_row(ROW_PREDICT, " ", 1'b1),
			text_row(ROW_PREDICT, " ", 1'b1),
			text_row(ROW_PREDICT, " ", 1'b0),
			text_row(ROW_PREDICT, CHAR_NL, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_pipeline();
				write_register(directed_rows[i].reg_index, directed_rows[i].value);
			end else begin
				send_text_byte(directed_rows[i].data_byte, directed_rows[i].end_of_text,
					directed_rows[i].kind);
			end
		end

		// Random phases, each under a fresh rule; the fourth runs with no idling at all.
		for (phase = 0; phase < 6; phase++) begin
			drain_pipeline();
			program_phase(phase);
			idle_pct = (phase == 3) ? 0 : 19;
			stall_pct = (phase == 3) ? 0 : 19;
			budget = (phase == 1 || phase == 3) ? 20 : (phase == 0) ? 6 : 8;
			send_random_text(budget);
		end

		drain_pipeline();
		if (error_count == 0 && expected_text.size() == 0) begin
			$display("marker_secret_redactor regression: pass");
		end else begin
			$display("marker_secret_redactor regression: fail");
		end
		$finish;
	end

endmodule
